>>> design/wcg_pkg.sv
// Shared types, constants and elaboration-time functions of the window coefficient generator.
`default_nettype none

package wcg_pkg;

   localparam int INDEX_BITS = 12;
   localparam int LEN_BITS   = 13;
   localparam int QUOT_BITS  = 33;
   localparam int NUM_BITS   = INDEX_BITS + QUOT_BITS;
   localparam int CORDIC_W   = 36;
   localparam int SHAPE_BITS = 2;

   localparam logic [SHAPE_BITS-1:0] SHAPE_SINE     = 2'd0;
   localparam logic [SHAPE_BITS-1:0] SHAPE_TRIANGLE = 2'd1;
   localparam logic [SHAPE_BITS-1:0] SHAPE_PHASOR   = 2'd2;
   localparam logic [SHAPE_BITS-1:0] SHAPE_HANN     = 2'd3;

   localparam logic [0:0] CSR_SHAPE  = 1'b0;
   localparam logic [0:0] CSR_LENGTH = 1'b1;

   localparam logic [LEN_BITS-1:0] LENGTH_RESET = 13'd4096;

   localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
   localparam logic [30:0] PI_Q29 = 31'h6487ED51;

   typedef struct packed {
      logic                  valid;
      logic                  err;
      logic [SHAPE_BITS-1:0] shape;
   } wcg_tag_type;

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] op;
      logic [63:0] res;
      logic [63:0] one;
      int          j;
      op  = v;
      res = '0;
      one = 64'd1 << 62;
      for (j = 0; j < 32; j++) begin
         if (one > op) begin
            one = one >> 2;
         end
      end
      for (j = 0; j < 32; j++) begin
         if (one != 64'd0) begin
            if (op >= res + one) begin
               op  = op - (res + one);
               res = (res >> 1) + one;
            end else begin
               res = res >> 1;
            end
            one = one >> 2;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] atan_q32(input int k);
      logic [63:0] sum;
      logic [63:0] pw;
      logic [63:0] term;
      int          n;
      sum = '0;
      if (k == 0) begin
         sum = (PI_Q62 >> 2) >> 30;
      end else begin
         pw = 64'd1 << (62 - k);
         for (n = 0; n < 32; n++) begin
            if (pw != 64'd0) begin
               term = udiv64(pw, 64'(2 * n + 1));
               if ((n % 2) == 0) begin
                  sum = sum + term;
               end else begin
                  sum = sum - term;
               end
               pw = pw >> (2 * k);
            end
         end
         sum = sum >> 30;
      end
      return sum;
   endfunction

   function automatic logic [63:0] cordic_x0(input int stages);
      logic [63:0] a2;
      int          k;
      a2 = 64'd1 << 60;
      for (k = 0; k < stages; k++) begin
         a2 = a2 + (a2 >> (2 * k));
      end
      return udiv64(64'd1 << 62, isqrt64(a2));
   endfunction

endpackage

`default_nettype wire

>>> design/wcg_div_cell.sv
// One restoring-division cell that produces one quotient bit per word.
`default_nettype none

module wcg_div_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire wcg_pkg::wcg_tag_type         in_tag,
   input  wire logic [wcg_pkg::LEN_BITS-1:0] in_rem,
   input  wire logic [wcg_pkg::QUOT_BITS-1:0] in_word,
   input  wire logic [wcg_pkg::LEN_BITS-1:0] in_div,
   output wcg_pkg::wcg_tag_type              out_tag,
   output logic [wcg_pkg::LEN_BITS-1:0]      out_rem,
   output logic [wcg_pkg::QUOT_BITS-1:0]     out_word,
   output logic [wcg_pkg::LEN_BITS-1:0]      out_div
);
   import wcg_pkg::*;

   logic [LEN_BITS:0]    shifted;
   logic [LEN_BITS:0]    diff;
   logic                 take;
   logic [LEN_BITS-1:0]  rem_in;
   logic [QUOT_BITS-1:0] word_in;
   wcg_tag_type          tag_ff;
   logic [LEN_BITS-1:0]  rem_ff;
   logic [QUOT_BITS-1:0] word_ff;
   logic [LEN_BITS-1:0]  div_ff;

   always_comb begin
      shifted = {in_rem, in_word[QUOT_BITS-1]};
      diff    = shifted - {1'b0, in_div};
      take    = (shifted >= {1'b0, in_div});
      rem_in  = take ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
      word_in = {in_word[QUOT_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         word_ff <= word_in;
         div_ff  <= in_div;
      end
   end

   assign out_tag  = tag_ff;
   assign out_rem  = rem_ff;
   assign out_word = word_ff;
   assign out_div  = div_ff;

endmodule

`default_nettype wire

>>> design/wcg_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and arctangent constant.
`default_nettype none

module wcg_cordic_cell #(
   parameter int STAGE    = 0,
   parameter int AUX_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                adv,
   input  wire wcg_pkg::wcg_tag_type                in_tag,
   input  wire logic signed [wcg_pkg::CORDIC_W-1:0] in_x,
   input  wire logic signed [wcg_pkg::CORDIC_W-1:0] in_y,
   input  wire logic signed [wcg_pkg::CORDIC_W-1:0] in_z,
   input  wire logic [AUX_BITS-1:0]                 in_aux,
   output wcg_pkg::wcg_tag_type                     out_tag,
   output logic signed [wcg_pkg::CORDIC_W-1:0]      out_x,
   output logic signed [wcg_pkg::CORDIC_W-1:0]      out_y,
   output logic signed [wcg_pkg::CORDIC_W-1:0]      out_z,
   output logic [AUX_BITS-1:0]                      out_aux
);
   import wcg_pkg::*;

   localparam logic signed [CORDIC_W-1:0] ANGLE = CORDIC_W'(atan_q32(STAGE));

   logic signed [CORDIC_W-1:0] dx;
   logic signed [CORDIC_W-1:0] dy;
   logic signed [CORDIC_W-1:0] x_in;
   logic signed [CORDIC_W-1:0] y_in;
   logic signed [CORDIC_W-1:0] z_in;
   wcg_tag_type                tag_ff;
   logic signed [CORDIC_W-1:0] x_ff;
   logic signed [CORDIC_W-1:0] y_ff;
   logic signed [CORDIC_W-1:0] z_ff;
   logic [AUX_BITS-1:0]        aux_ff;

   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      if (!in_z[CORDIC_W-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ANGLE;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         aux_ff <= in_aux;
      end
   end

   assign out_tag = tag_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;
   assign out_aux = aux_ff;

endmodule

`default_nettype wire

>>> design/window_coefficient_generator_top.sv
// Top level of the window coefficient generator: setup, divider chain, CORDIC chain and output.
// Registers in order: tag0, divider cells, fold, mul, CORDIC cells, p1, p2, rsp.
// Throughput is one index per cycle; each divider cell and CORDIC cell takes a new word every cycle,
// except that the whole pipeline holds while a finished word waits under rsp_stall.
// Synchronous reset empties the pipeline and sets the shape to sine and the length to 4096.
`default_nettype none

module window_coefficient_generator_top #(
   parameter int MAX_LENGTH    = 4096,
   parameter int VALUE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [wcg_pkg::INDEX_BITS-1:0]      req_sample_index,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [VALUE_BITS-1:0]                    rsp_window_value,
   output logic                                     rsp_index_error,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [0:0]                          csr_index,
   input  wire logic [wcg_pkg::LEN_BITS-1:0]        csr_data
);
   import wcg_pkg::*;

   localparam logic [LEN_BITS-1:0] LEN_CAP =
      (MAX_LENGTH >= (1 << LEN_BITS) - 1) ? {LEN_BITS{1'b1}} : LEN_BITS'(MAX_LENGTH);
   localparam logic [QUOT_BITS-1:0] HALF_TURN = QUOT_BITS'(64'd1 << 31);
   localparam logic [QUOT_BITS-1:0] FULL_TURN = QUOT_BITS'(64'd1 << 32);
   localparam logic [QUOT_BITS-1:0] LIN_TOP   = QUOT_BITS'((64'd1 << VALUE_BITS) - 64'd1);
   localparam logic [VALUE_BITS:0]  VAL_TOP   = {1'b0, {VALUE_BITS{1'b1}}};
   localparam int SIN_SH  = 32 - VALUE_BITS;
   localparam int HANN_SH = 62 - VALUE_BITS;
   localparam logic signed [CORDIC_W-1:0] X_INIT = CORDIC_W'(cordic_x0(CORDIC_STAGES));
   localparam logic signed [CORDIC_W-1:0] Y_ONE  = CORDIC_W'(64'd1 << 32);

   logic                   adv;
   logic [SHAPE_BITS-1:0]  shape_ff;
   logic [LEN_BITS-1:0]    length_ff;

   logic [LEN_BITS-1:0]    eff_len;
   logic [LEN_BITS-1:0]    twice;
   logic [LEN_BITS-1:0]    tri_dist;
   logic [NUM_BITS-1:0]    num_in;
   logic [LEN_BITS-1:0]    div_in;
   wcg_tag_type            tag_in;

   wcg_tag_type            tag0_ff;
   logic [LEN_BITS-1:0]    rem0_ff;
   logic [QUOT_BITS-1:0]   word0_ff;
   logic [LEN_BITS-1:0]    div0_ff;

   wcg_tag_type            dv_tag  [0:QUOT_BITS];
   logic [LEN_BITS-1:0]    dv_rem  [0:QUOT_BITS];
   logic [QUOT_BITS-1:0]   dv_word [0:QUOT_BITS];
   logic [LEN_BITS-1:0]    dv_div  [0:QUOT_BITS];

   logic [QUOT_BITS-1:0]   quot;
   logic [QUOT_BITS-1:0]   phase_wide;
   logic [31:0]            phase_in;
   logic [VALUE_BITS-1:0]  lin_in;
   wcg_tag_type            fold_tag_ff;
   logic [31:0]            phase_ff;
   logic [VALUE_BITS-1:0]  lin_ff;

   logic [62:0]            angle_prod;
   wcg_tag_type            mul_tag_ff;
   logic signed [CORDIC_W-1:0] angle_ff;
   logic [VALUE_BITS-1:0]  lin_mul_ff;

   wcg_tag_type                cr_tag [0:CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] cr_x   [0:CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] cr_y   [0:CORDIC_STAGES];
   logic signed [CORDIC_W-1:0] cr_z   [0:CORDIC_STAGES];
   logic [VALUE_BITS-1:0]      cr_aux [0:CORDIC_STAGES];

   logic signed [CORDIC_W-1:0] y_last;
   logic [32:0]            sin_clamped;
   logic [34:0]            sin_sum;
   logic [34:0]            sin_round;
   logic [VALUE_BITS-1:0]  sin_in;
   wcg_tag_type            p1_tag_ff;
   logic [VALUE_BITS-1:0]  sin_ff;
   logic [31:0]            half_ff;
   logic [VALUE_BITS-1:0]  lin_p1_ff;

   wcg_tag_type            p2_tag_ff;
   logic [63:0]            square_ff;
   logic [VALUE_BITS-1:0]  sin_p2_ff;
   logic [VALUE_BITS-1:0]  lin_p2_ff;

   logic [63:0]            hann_sum;
   logic [63:0]            hann_round;
   logic [VALUE_BITS-1:0]  hann_val;
   logic [VALUE_BITS-1:0]  value_in;
   logic                   rsp_valid_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff;
   logic                   rsp_error_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff  <= SHAPE_SINE;
         length_ff <= LENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SHAPE:  shape_ff  <= csr_data[SHAPE_BITS-1:0];
            CSR_LENGTH: length_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      eff_len  = (length_ff > LEN_CAP) ? LEN_CAP : length_ff;
      twice    = {req_sample_index, 1'b0};
      tri_dist = (twice >= eff_len) ? twice - eff_len : eff_len - twice;
      case (shape_ff)
         SHAPE_PHASOR: begin
            num_in = (NUM_BITS'(req_sample_index) << VALUE_BITS) + NUM_BITS'(eff_len >> 1);
         end
         SHAPE_TRIANGLE: begin
            num_in = (NUM_BITS'(tri_dist) << VALUE_BITS) + NUM_BITS'(eff_len >> 1);
         end
         default: begin
            num_in = NUM_BITS'(req_sample_index) << 32;
         end
      endcase
      if (shape_ff == SHAPE_HANN) begin
         div_in = (eff_len > 13'd1) ? eff_len - 13'd1 : 13'd1;
      end else begin
         div_in = eff_len;
      end
      tag_in.valid = req_valid;
      tag_in.err   = ({1'b0, req_sample_index} >= eff_len);
      tag_in.shape = shape_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else if (adv) begin
         tag0_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem0_ff  <= LEN_BITS'(num_in[NUM_BITS-1:QUOT_BITS]);
         word0_ff <= num_in[QUOT_BITS-1:0];
         div0_ff  <= div_in;
      end
   end

   assign dv_tag[0]  = tag0_ff;
   assign dv_rem[0]  = rem0_ff;
   assign dv_word[0] = word0_ff;
   assign dv_div[0]  = div0_ff;

   for (genvar g = 0; g < QUOT_BITS; g++) begin : g_div
      wcg_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_tag   (dv_tag[g]),
         .in_rem   (dv_rem[g]),
         .in_word  (dv_word[g]),
         .in_div   (dv_div[g]),
         .out_tag  (dv_tag[g+1]),
         .out_rem  (dv_rem[g+1]),
         .out_word (dv_word[g+1]),
         .out_div  (dv_div[g+1])
      );
   end

   always_comb begin
      quot       = dv_word[QUOT_BITS];
      phase_wide = (quot > HALF_TURN) ? FULL_TURN - quot : quot;
      phase_in   = phase_wide[31:0];
      lin_in     = (quot > LIN_TOP) ? LIN_TOP[VALUE_BITS-1:0] : quot[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_tag_ff <= '0;
         mul_tag_ff  <= '0;
      end else if (adv) begin
         fold_tag_ff <= dv_tag[QUOT_BITS];
         mul_tag_ff  <= fold_tag_ff;
      end
   end

   assign angle_prod = 63'(phase_ff) * 63'(PI_Q29);

   always_ff @(posedge clock) begin
      if (adv) begin
         phase_ff   <= phase_in;
         lin_ff     <= lin_in;
         angle_ff   <= CORDIC_W'(angle_prod[62:29]);
         lin_mul_ff <= lin_ff;
      end
   end

   assign cr_tag[0] = mul_tag_ff;
   assign cr_x[0]   = X_INIT;
   assign cr_y[0]   = '0;
   assign cr_z[0]   = angle_ff;
   assign cr_aux[0] = lin_mul_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      wcg_cordic_cell #(
         .STAGE    (g),
         .AUX_BITS (VALUE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .in_tag  (cr_tag[g]),
         .in_x    (cr_x[g]),
         .in_y    (cr_y[g]),
         .in_z    (cr_z[g]),
         .in_aux  (cr_aux[g]),
         .out_tag (cr_tag[g+1]),
         .out_x   (cr_x[g+1]),
         .out_y   (cr_y[g+1]),
         .out_z   (cr_z[g+1]),
         .out_aux (cr_aux[g+1])
      );
   end

   always_comb begin
      y_last = cr_y[CORDIC_STAGES];
      if (y_last[CORDIC_W-1]) begin
         sin_clamped = '0;
      end else if (y_last > Y_ONE) begin
         sin_clamped = 33'(Y_ONE);
      end else begin
         sin_clamped = y_last[32:0];
      end
      sin_sum   = ({2'b0, sin_clamped} << 1) + (35'd1 << SIN_SH);
      sin_round = sin_sum >> (SIN_SH + 1);
      sin_in    = (sin_round[VALUE_BITS:0] > VAL_TOP) ? VAL_TOP[VALUE_BITS-1:0]
                                                      : sin_round[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff <= '0;
         p2_tag_ff <= '0;
      end else if (adv) begin
         p1_tag_ff <= cr_tag[CORDIC_STAGES];
         p2_tag_ff <= p1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff    <= sin_in;
         half_ff   <= sin_clamped[32:1];
         lin_p1_ff <= cr_aux[CORDIC_STAGES];
         square_ff <= 64'(half_ff) * 64'(half_ff);
         sin_p2_ff <= sin_ff;
         lin_p2_ff <= lin_p1_ff;
      end
   end

   always_comb begin
      hann_sum   = (square_ff << 1) + (64'd1 << HANN_SH);
      hann_round = hann_sum >> (HANN_SH + 1);
      hann_val   = (hann_round[VALUE_BITS:0] > VAL_TOP) ? VAL_TOP[VALUE_BITS-1:0]
                                                        : hann_round[VALUE_BITS-1:0];
      if (p2_tag_ff.err) begin
         value_in = '0;
      end else begin
         case (p2_tag_ff.shape)
            SHAPE_HANN:     value_in = hann_val;
            SHAPE_SINE:     value_in = sin_p2_ff;
            SHAPE_TRIANGLE: value_in = lin_p2_ff;
            SHAPE_PHASOR:   value_in = lin_p2_ff;
            default:        value_in = sin_p2_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p2_tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= value_in;
         rsp_error_ff <= p2_tag_ff.err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_value = rsp_value_ff;
   assign rsp_index_error  = rsp_error_ff;

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff |-> rsp_value_ff == '0)
      else $error("An out-of-range index gave a nonzero coefficient.");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !tag0_ff.valid)
      else $error("The pipeline holds a word right after reset.");

   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(tag0_ff) && $stable(p2_tag_ff))
      else $error("The pipeline advanced while the output was held.");

endmodule

`default_nettype wire

>>> tb/tb_window_coefficient_generator_top.sv
// Self-checking testbench of the window coefficient generator: directed, random and stall tests.
`default_nettype none

module tb_window_coefficient_generator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wcg_pkg::*;

   localparam int DRAIN_CYCLES = 70;
   localparam int CYCLE_LIMIT  = 300000;
   localparam longint unsigned PI_Q62_C = 64'hC90FDAA22168C234;

   typedef struct packed {
      logic [15:0] window_value;
      logic        index_error;
   } coeff_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [INDEX_BITS-1:0] req_sample_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [15:0]           rsp_window_value;
   logic                  rsp_index_error;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [0:0]            csr_index = CSR_SHAPE;
   logic [LEN_BITS-1:0]   csr_data = '0;

   logic [SHAPE_BITS-1:0] cur_shape = SHAPE_SINE;
   logic [LEN_BITS-1:0]   cur_length = LENGTH_RESET;
   coeff_word_type        pending_coeffs[$];
   int                    error_count = 0;
   int                    words_checked = 0;
   int                    words_sent = 0;
   int                    cycle_count = 0;
   bit                    idle_enable = 1'b1;
   int                    hold_cycles = 0;

   window_coefficient_generator_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_index(req_sample_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_window_value(rsp_window_value), .rsp_index_error(rsp_index_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned arctan_q32(int k);
      longint unsigned sum;
      longint unsigned pw;
      longint unsigned n;
      sum = 0;
      n = 0;
      if (k == 0) begin
         return (PI_Q62_C >> 2) >> 30;
      end
      pw = 64'd1 << (62 - k);
      while (pw != 0) begin
         if (n[0] == 1'b0) begin
            sum = sum + pw / (2 * n + 1);
         end else begin
            sum = sum - pw / (2 * n + 1);
         end
         pw = pw >> (2 * k);
         n++;
      end
      return sum >> 30;
   endfunction

   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned op;
      longint unsigned res;
      longint unsigned bitv;
      op = v;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > op) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (op >= res + bitv) begin
            op = op - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned sine_of_turn(longint unsigned t);
      longint unsigned a2;
      longint          x;
      longint          y;
      longint          z;
      longint          dx;
      longint          dy;
      longint unsigned phase;
      phase = t;
      a2 = 64'd1 << 60;
      y = 0;
      if (phase > (64'd1 << 31)) phase = (64'd1 << 32) - phase;
      z = longint'((phase * (PI_Q62_C >> 33)) >> 29);
      for (int k = 0; k < 16; k++) a2 = a2 + (a2 >> (2 * k));
      x = longint'((64'd1 << 62) / root_of(a2));
      for (int k = 0; k < 16; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(arctan_q32(k));
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(arctan_q32(k));
         end
      end
      if (y < 0) y = 0;
      if (y > (64'sd1 <<< 32)) y = 64'sd1 <<< 32;
      return longint'(y);
   endfunction

   function automatic coeff_word_type predict_coeff(logic [INDEX_BITS-1:0] idx);
      coeff_word_type  w;
      longint unsigned i;
      longint unsigned len;
      longint unsigned v;
      longint unsigned d;
      longint unsigned s;
      i = idx;
      len = cur_length;
      if (len > 4096) len = 4096;
      w = '0;
      if (i >= len) begin
         w.index_error = 1'b1;
         return w;
      end
      case (cur_shape)
         SHAPE_PHASOR: begin
            v = ((i << 16) + len / 2) / len;
         end
         SHAPE_TRIANGLE: begin
            d = (2 * i >= len) ? 2 * i - len : len - 2 * i;
            v = ((d << 16) + len / 2) / len;
         end
         SHAPE_HANN: begin
            s = sine_of_turn((len > 1) ? (i << 32) / (len - 1) : 0) >> 1;
            v = (s * s + (64'd1 << 45)) >> 46;
         end
         default: begin
            v = (sine_of_turn((i << 32) / len) + (64'd1 << 15)) >> 16;
         end
      endcase
      w.window_value = (v > 65535) ? 16'hFFFF : v[15:0];
      return w;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      coeff_word_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pending_coeffs.size() == 0) begin
            $error("Unexpected word: window_value %0d index_error %0d",
                   rsp_window_value, rsp_index_error);
            error_count++;
         end else begin
            exp_word = pending_coeffs.pop_front();
            if (rsp_window_value !== exp_word.window_value) begin
               $error("window_value: expected %0d, actual %0d",
                      exp_word.window_value, rsp_window_value);
               error_count++;
            end
            if (rsp_index_error !== exp_word.index_error) begin
               $error("index_error: expected %0d, actual %0d",
                      exp_word.index_error, rsp_index_error);
               error_count++;
            end
         end
      end
   end

   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_index(logic [INDEX_BITS-1:0] idx);
      coeff_word_type exp_word;
      exp_word = predict_coeff(idx);
      req_valid <= 1'b1;
      req_sample_index <= idx;
      do @(posedge clock); while (req_stall);
      pending_coeffs.push_back(exp_word);
      words_sent++;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         req_sample_index <= INDEX_BITS'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_coeffs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [LEN_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SHAPE) begin
         cur_shape = data[SHAPE_BITS-1:0];
      end else begin
         cur_length = data;
      end
      @(posedge clock);
   endtask

   task automatic set_window(logic [SHAPE_BITS-1:0] shape, logic [LEN_BITS-1:0] len);
      drain_pipeline();
      write_csr(CSR_SHAPE, {(LEN_BITS - SHAPE_BITS)'($urandom_range(0, 2047)), shape});
      write_csr(CSR_LENGTH, len);
   endtask

   function automatic logic [LEN_BITS-1:0] random_length();
      case ($urandom_range(0, 9))
         0: return 13'd2;
         1: return 13'd4096;
         2: return LEN_BITS'($urandom_range(0, 8191));
         3: return LEN_BITS'($urandom_range(2, 16));
         default: return LEN_BITS'($urandom_range(2, 4096));
      endcase
   endfunction

   function automatic logic [INDEX_BITS-1:0] random_index();
      int lim;
      lim = (cur_length > 4096) ? 4096 : int'(cur_length);
      if (lim == 0 || $urandom_range(0, 7) == 0) return INDEX_BITS'($urandom);
      return INDEX_BITS'($urandom_range(0, lim - 1));
   endfunction

   task automatic test_reset_defaults();
      send_index(12'd0);
      send_index(12'd2048);
      send_index(12'd4095);
   endtask

   task automatic test_shape_extremes();
      set_window(SHAPE_TRIANGLE, 13'd4096);
      send_index(12'd0); send_index(12'd2048); send_index(12'd4095);
      set_window(SHAPE_PHASOR, 13'd4096);
      send_index(12'd0); send_index(12'd2048); send_index(12'd4095);
      set_window(SHAPE_HANN, 13'd4096);
      send_index(12'd0); send_index(12'd2048); send_index(12'd4095);
   endtask

   task automatic test_length_corners();
      set_window(SHAPE_HANN, 13'd2);
      send_index(12'd0); send_index(12'd1); send_index(12'd2);
      set_window(SHAPE_HANN, 13'd1);
      send_index(12'd0); send_index(12'd1);
      set_window(SHAPE_SINE, 13'd1);
      send_index(12'd0);
      set_window(SHAPE_PHASOR, 13'd0);
      send_index(12'd0);
      set_window(SHAPE_PHASOR, 13'd8191);
      send_index(12'd4095);
      set_window(SHAPE_TRIANGLE, 13'd4097);
      send_index(12'd4095);
   endtask

   task automatic test_random_windows();
      for (int p = 0; p < 12; p++) begin
         set_window(SHAPE_BITS'($urandom_range(0, 3)), random_length());
         repeat (50) send_index(random_index());
      end
   endtask

   task automatic test_output_hold();
      set_window(SHAPE_BITS'($urandom_range(0, 3)), LEN_BITS'($urandom_range(2, 4096)));
      hold_cycles = 150;
      repeat (80) send_index(random_index());
   endtask

   task automatic test_full_rate();
      set_window(SHAPE_SINE, 13'd4096);
      idle_enable = 1'b0;
      repeat (90) send_index(random_index());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_shape_extremes();
      test_length_corners();
      test_random_windows();
      test_output_hold();
      test_full_rate();
      drain_pipeline();
      $display("Sent %0d indexes and checked %0d coefficient words over all four shapes,",
               words_sent, words_checked);
      $display("including lengths 0, 1, 2, 4096 and above, out-of-range indexes and long stalls.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
